/* hw/rtl/ptm_pkg.sv */
// ----------------------------------------------------------------------------
// ptm_pkg
// Shared types and constants of the Pauli-term matrix-vector core.
// ----------------------------------------------------------------------------
package ptm_pkg;

    // default sizes
    localparam int SPIN_BITS_DEF = 16;
    localparam int MAX_TERMS_DEF = 64;
    localparam int ACC_DEPTH_DEF = 1024;

    // field widths
    localparam int FUNC_W   = 2;
    localparam int SLOT_W   = 10;
    localparam int MASK_W   = 16;
    localparam int COEFF_W  = 16;
    localparam int COL_W    = 16;
    localparam int X_W      = 16;
    localparam int ACC_W    = 40;
    localparam int PROD_W   = 32;
    localparam int S_DATA_W = 112;
    localparam int M_DATA_W = 40;
    localparam int TERM_W   = 3 * MASK_W + COEFF_W;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int TCNT_CFG_W = 7;
    localparam int ROWL_W     = 16;
    localparam int ROWH_W     = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_TERM_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_HIGH   = 2'd2;

    localparam logic [ROWH_W-1:0] ROW_HIGH_RESET = 17'd1024;

    // item functions
    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_APPLY = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd3;

    // controller states
    typedef enum logic [3:0] {
        ST_INIT_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_CLEAR,
        ST_TERM_ADDR,
        ST_TERM_EVAL,
        ST_ACC_READ,
        ST_ACC_WRITE,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic load_term;
        logic eval;
        logic acc_issue;
        logic acc_write;
        logic rd_issue;
        logic rd_capture;
        logic clr_step;
        logic out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic term_none;
        logic term_last;
        logic clr_last;
        logic out_free;
    } status_t;

endpackage

/* hw/rtl/ptm_ram.sv */
// ----------------------------------------------------------------------------
// ptm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ptm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/ptm_ctrl.sv */
// ----------------------------------------------------------------------------
// ptm_ctrl
// Sequencer for load, clear, apply and read items.
// ----------------------------------------------------------------------------
module ptm_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_valid,
    input  logic [ptm_pkg::FUNC_W-1:0]   s_func,
    output logic                         s_ready,
    input  ptm_pkg::status_t             status,
    output ptm_pkg::cmd_t                cmd
);

    ptm_pkg::state_t state_reg, state_next;
    logic            accept;

    assign accept = s_valid && (state_reg == ptm_pkg::ST_IDLE);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ptm_pkg::ST_INIT_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ptm_pkg::ST_INIT_CLEAR:
            begin
                if (status.clr_last)
                begin
                    state_next = ptm_pkg::ST_IDLE;
                end
            end
            ptm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (s_func)
                        ptm_pkg::FUNC_LOAD:  state_next = ptm_pkg::ST_LOAD;
                        ptm_pkg::FUNC_CLEAR: state_next = ptm_pkg::ST_CLEAR;
                        ptm_pkg::FUNC_APPLY:
                        begin
                            state_next = status.term_none ? ptm_pkg::ST_DONE
                                                          : ptm_pkg::ST_TERM_ADDR;
                        end
                        default:             state_next = ptm_pkg::ST_RD_ADDR;
                    endcase
                end
            end
            ptm_pkg::ST_LOAD:      state_next = ptm_pkg::ST_DONE;
            ptm_pkg::ST_CLEAR:
            begin
                if (status.clr_last)
                begin
                    state_next = ptm_pkg::ST_DONE;
                end
            end
            ptm_pkg::ST_TERM_ADDR: state_next = ptm_pkg::ST_TERM_EVAL;
            ptm_pkg::ST_TERM_EVAL: state_next = ptm_pkg::ST_ACC_READ;
            ptm_pkg::ST_ACC_READ:  state_next = ptm_pkg::ST_ACC_WRITE;
            ptm_pkg::ST_ACC_WRITE:
            begin
                state_next = status.term_last ? ptm_pkg::ST_DONE : ptm_pkg::ST_TERM_ADDR;
            end
            ptm_pkg::ST_RD_ADDR:   state_next = ptm_pkg::ST_RD_DATA;
            ptm_pkg::ST_RD_DATA:   state_next = ptm_pkg::ST_DONE;
            ptm_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ptm_pkg::ST_IDLE;
                end
            end
            default:               state_next = ptm_pkg::ST_IDLE;
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd         = '0;
        s_ready     = 1'b0;
        case (state_reg)
            ptm_pkg::ST_INIT_CLEAR: cmd.clr_step = 1'b1;
            ptm_pkg::ST_IDLE:
            begin
                s_ready     = 1'b1;
                cmd.capture = accept;
            end
            ptm_pkg::ST_LOAD:       cmd.load_term  = 1'b1;
            ptm_pkg::ST_CLEAR:      cmd.clr_step   = 1'b1;
            ptm_pkg::ST_TERM_ADDR:  cmd            = '0;
            ptm_pkg::ST_TERM_EVAL:  cmd.eval       = 1'b1;
            ptm_pkg::ST_ACC_READ:   cmd.acc_issue  = 1'b1;
            ptm_pkg::ST_ACC_WRITE:  cmd.acc_write  = 1'b1;
            ptm_pkg::ST_RD_ADDR:    cmd.rd_issue   = 1'b1;
            ptm_pkg::ST_RD_DATA:    cmd.rd_capture = 1'b1;
            ptm_pkg::ST_DONE:       cmd.out_load   = status.out_free;
            default:                cmd            = '0;
        endcase
    end

endmodule

/* hw/rtl/ptm_datapath.sv */
// ----------------------------------------------------------------------------
// ptm_datapath
// Term store, accumulator store, term evaluation, saturating update, output.
// ----------------------------------------------------------------------------
module ptm_datapath #(
    parameter int SPIN_BITS = ptm_pkg::SPIN_BITS_DEF,
    parameter int MAX_TERMS = ptm_pkg::MAX_TERMS_DEF,
    parameter int ACC_DEPTH = ptm_pkg::ACC_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [ptm_pkg::S_DATA_W-1:0]    s_data,
    input  logic                            cfg_we,
    input  logic [ptm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ptm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            m_ready,
    output logic                            m_valid,
    output logic [ptm_pkg::M_DATA_W-1:0]    m_data,
    output logic                            m_sat,
    input  ptm_pkg::cmd_t                   cmd,
    output ptm_pkg::status_t                status
);

    localparam int TERM_AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int TCNT_W  = $clog2(MAX_TERMS + 1);
    localparam int ACC_AW  = $clog2(ACC_DEPTH);
    localparam int MW      = ptm_pkg::MASK_W;
    localparam int AW      = ptm_pkg::ACC_W;
    localparam int TERM_W_LOCAL = ptm_pkg::TERM_W;
    localparam logic [MW-1:0] SPIN_MASK =
        (SPIN_BITS >= MW) ? {MW{1'b1}} : MW'((32'd1 << SPIN_BITS) - 32'd1);
    localparam logic [16:0] DEPTH17  = 17'(ACC_DEPTH);
    localparam logic [10:0] MAXT11   = 11'(MAX_TERMS);
    localparam logic signed [AW:0] ACC_MAX41 = 41'sh7F_FFFF_FFFF;
    localparam logic signed [AW:0] ACC_MIN41 = -41'sh80_0000_0000;

    // configuration registers
    logic [ptm_pkg::TCNT_CFG_W-1:0] term_count_reg;
    logic [ptm_pkg::ROWL_W-1:0]     row_low_reg;
    logic [ptm_pkg::ROWH_W-1:0]     row_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_count_reg <= '0;
            row_low_reg    <= '0;
            row_high_reg   <= ptm_pkg::ROW_HIGH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ptm_pkg::CFG_TERM_COUNT: term_count_reg <= cfg_data[6:0];
                ptm_pkg::CFG_ROW_LOW:    row_low_reg    <= cfg_data[15:0];
                ptm_pkg::CFG_ROW_HIGH:   row_high_reg   <= cfg_data;
                default:                 term_count_reg <= term_count_reg;
            endcase
        end
    end

    // active term count clamped to the store size
    logic [10:0]       tcnt11;
    logic [TCNT_W-1:0] n_terms;
    assign tcnt11  = (11'(term_count_reg) > MAXT11) ? MAXT11 : 11'(term_count_reg);
    assign n_terms = tcnt11[TCNT_W-1:0];

    // captured item fields
    logic [ptm_pkg::SLOT_W-1:0]         slot_reg;
    logic [TERM_W_LOCAL-1:0]            term_in_reg;
    logic [ptm_pkg::COL_W-1:0]          col_reg;
    logic signed [ptm_pkg::X_W-1:0]     x_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            slot_reg    <= s_data[9:0];
            term_in_reg <= s_data[73:10];
            col_reg     <= s_data[89:74];
            x_reg       <= s_data[105:90];
        end
    end

    // term counter
    logic [TCNT_W-1:0] t_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_reg <= '0;
        end
        else if (cmd.capture)
        begin
            t_reg <= '0;
        end
        else if (cmd.acc_write)
        begin
            t_reg <= t_reg + TCNT_W'(1);
        end
    end

    // term store
    logic                    term_we;
    logic [TERM_AW-1:0]      term_waddr;
    logic [TERM_W_LOCAL-1:0] term_rdata;
    assign term_we    = cmd.load_term && ({1'b0, slot_reg} < MAXT11);
    assign term_waddr = TERM_AW'(slot_reg);

    ptm_ram #(
        .WIDTH (TERM_W_LOCAL),
        .DEPTH (MAX_TERMS)
    ) u_term_ram (
        .clk   (clk),
        .we    (term_we),
        .waddr (term_waddr),
        .wdata (term_in_reg),
        .raddr (t_reg[TERM_AW-1:0]),
        .rdata (term_rdata)
    );

    // term evaluation
    logic [MW-1:0] col_m, flip, zm, ym, row16;
    logic signed [ptm_pkg::COEFF_W-1:0] coeff;
    logic [4:0]    kcnt;
    logic [16:0]   idx17;
    logic          in_win, ok, neg;

    always_comb
    begin
        flip   = term_rdata[15:0];
        zm     = term_rdata[31:16];
        ym     = term_rdata[47:32] & SPIN_MASK;
        coeff  = term_rdata[63:48];
        col_m  = col_reg & SPIN_MASK;
        row16  = (col_m ^ flip) & SPIN_MASK;
        kcnt   = '0;
        for (int i = 0; i < MW; i++)
        begin
            kcnt = kcnt + 5'(ym[i]);
        end
        in_win = ({1'b0, row16} >= {1'b0, row_low_reg}) && ({1'b0, row16} < row_high_reg);
        idx17  = {1'b0, row16} - {1'b0, row_low_reg};
        ok     = in_win && (idx17 < DEPTH17) && !kcnt[0];
        neg    = (^(col_m & zm)) ^ kcnt[1] ^ (^(row16 & ym));
    end

    logic [ACC_AW-1:0]               idx_reg;
    logic                            ok_reg, neg_reg;
    logic signed [ptm_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            idx_reg  <= idx17[ACC_AW-1:0];
            ok_reg   <= ok;
            neg_reg  <= neg;
            prod_reg <= coeff * x_reg;
        end
    end

    // clear sweep counter
    logic [ACC_AW-1:0] clr_reg;
    logic              clr_last;
    assign clr_last = (17'(clr_reg) == DEPTH17 - 17'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_reg <= clr_last ? '0 : clr_reg + ACC_AW'(1);
        end
    end

    // saturating accumulate
    logic [AW-1:0]        acc_rdata;
    logic signed [AW:0]   acc_ext, prod_ext, sum41;
    logic [AW-1:0]        sum_sat;
    logic                 sat_hit;

    always_comb
    begin
        acc_ext  = {acc_rdata[AW-1], acc_rdata};
        prod_ext = 41'(prod_reg);
        sum41    = neg_reg ? (acc_ext - prod_ext) : (acc_ext + prod_ext);
        sat_hit  = (sum41 > ACC_MAX41) || (sum41 < ACC_MIN41);
        if (sum41 > ACC_MAX41)
        begin
            sum_sat = ACC_MAX41[AW-1:0];
        end
        else if (sum41 < ACC_MIN41)
        begin
            sum_sat = ACC_MIN41[AW-1:0];
        end
        else
        begin
            sum_sat = sum41[AW-1:0];
        end
    end

    // accumulator store ports
    logic              acc_we;
    logic [ACC_AW-1:0] acc_waddr, acc_raddr;
    logic [AW-1:0]     acc_wdata;
    logic [16:0]       slot17;
    assign slot17    = {7'd0, slot_reg};
    assign acc_we    = cmd.clr_step || (cmd.acc_write && ok_reg);
    assign acc_waddr = cmd.clr_step ? clr_reg : idx_reg;
    assign acc_wdata = cmd.clr_step ? '0 : sum_sat;
    assign acc_raddr = cmd.rd_issue ? slot17[ACC_AW-1:0] : idx_reg;

    ptm_ram #(
        .WIDTH (AW),
        .DEPTH (ACC_DEPTH)
    ) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .raddr (acc_raddr),
        .rdata (acc_rdata)
    );

    // result value and saturation flag of the current item
    logic [AW-1:0] rd_val_reg;
    logic          sat_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rd_val_reg <= '0;
            sat_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.rd_capture && (slot17 < DEPTH17))
            begin
                rd_val_reg <= acc_rdata;
            end
            if (cmd.acc_write && ok_reg && sat_hit)
            begin
                sat_reg <= 1'b1;
            end
        end
    end

    // output register
    logic          out_valid_reg;
    logic [AW-1:0] out_data_reg;
    logic          out_sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= rd_val_reg;
            out_sat_reg  <= sat_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;
    assign m_sat   = out_sat_reg;

    // status to controller
    assign status.term_none = (n_terms == '0);
    assign status.term_last = (t_reg == n_terms - TCNT_W'(1));
    assign status.clr_last  = clr_last;
    assign status.out_free  = !out_valid_reg || m_ready;

endmodule

/* hw/rtl/pauli_term_matvec_core.sv */
// ----------------------------------------------------------------------------
// pauli_term_matvec_core
// Matrix-free product of a Pauli-string Hamiltonian with a vector.
// ----------------------------------------------------------------------------
//  channel   direction  fields
//  s_axis    in         tuser: func; tdata: slot, flip, z, y, coeff, col, x
//  m_axis    out        tuser: saturated; tdata: read_value
//  cfg       in         cfg_index, cfg_data (term_count, row_low, row_high)
//
//  an apply item runs term address, evaluation, accumulator read and write for
//  each active term; the term loop shares one accumulator read-modify-write path
//  a clear sweeps all ACC_DEPTH accumulator entries
//  after reset a clearing pass over all ACC_DEPTH entries runs before the first item
//  a result waiting on m_tready holds the next item in its done state only
// ----------------------------------------------------------------------------
module pauli_term_matvec_core #(
    parameter int SPIN_BITS = ptm_pkg::SPIN_BITS_DEF,
    parameter int MAX_TERMS = ptm_pkg::MAX_TERMS_DEF,
    parameter int ACC_DEPTH = ptm_pkg::ACC_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // slot[9:0], flip_mask[25:10], z_mask[41:26], y_mask[57:42],
    // coefficient[73:58], col_index[89:74], x_value[105:90], zero fill
    input  logic [ptm_pkg::S_DATA_W-1:0]    s_tdata,
    // func[1:0]
    input  logic [ptm_pkg::FUNC_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // read_value[39:0]
    output logic [ptm_pkg::M_DATA_W-1:0]    m_tdata,
    // saturated[0]
    output logic [0:0]                      m_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ptm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ptm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    ptm_pkg::cmd_t    cmd;
    ptm_pkg::status_t status;
    logic             sat;

    assign cfg_ready  = 1'b1;
    assign m_tuser[0] = sat;

    // sequencer
    ptm_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_tvalid),
        .s_func  (s_tuser),
        .s_ready (s_tready),
        .status  (status),
        .cmd     (cmd)
    );

    // datapath
    ptm_datapath #(
        .SPIN_BITS (SPIN_BITS),
        .MAX_TERMS (MAX_TERMS),
        .ACC_DEPTH (ACC_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_data    (s_tdata),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_ready   (m_tready),
        .m_valid   (m_tvalid),
        .m_data    (m_tdata),
        .m_sat     (sat),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

/* test/tb_pauli_term_matvec_core.sv */
// ----------------------------------------------------------------------------
// tb_pauli_term_matvec_core
// Self-checking bench for the Pauli-term matrix-vector core. A scoreboard
// predicts every result from its own copy of the terms, the accumulators and
// the window registers. Directed items cover the extremes and saturation;
// random phases follow under several window settings, with random idling in all but the last.
// ----------------------------------------------------------------------------
module tb_pauli_term_matvec_core;

    localparam int  N_TERMS  = ptm_pkg::MAX_TERMS_DEF;
    localparam int  N_ACC    = ptm_pkg::ACC_DEPTH_DEF;
    localparam int  LIMIT    = 3000000;
    localparam int  N_PHASES = 8;

    // expected results and the block's predicted state
    class matvec_scoreboard;
        logic [ptm_pkg::MASK_W-1:0]         flip [N_TERMS];
        logic [ptm_pkg::MASK_W-1:0]         zmsk [N_TERMS];
        logic [ptm_pkg::MASK_W-1:0]         ymsk [N_TERMS];
        logic signed [ptm_pkg::COEFF_W-1:0] coef [N_TERMS];
        longint                   acc  [N_ACC];
        int unsigned              term_count;
        int unsigned              row_low;
        int unsigned              row_high;
        logic [40:0]              pending_q [$];
        int                       errors;

        function void reset_state();
            foreach (acc[i]) acc[i] = 0;
            term_count = 0;
            row_low    = 0;
            row_high   = 32'(ptm_pkg::ROW_HIGH_RESET);
            errors     = 0;
        endfunction

        function void write_reg(logic [ptm_pkg::CFG_IDX_W-1:0] idx,
                                logic [ptm_pkg::CFG_DATA_W-1:0] val);
            if (idx == ptm_pkg::CFG_TERM_COUNT)
                term_count = 32'(val[ptm_pkg::TCNT_CFG_W-1:0]);
            else if (idx == ptm_pkg::CFG_ROW_LOW)
                row_low = 32'(val[ptm_pkg::ROWL_W-1:0]);
            else if (idx == ptm_pkg::CFG_ROW_HIGH)
                row_high = 32'(val[ptm_pkg::ROWH_W-1:0]);
        endfunction

        // predict the result of one accepted item
        function void note_item(logic [ptm_pkg::FUNC_W-1:0] fn,
                                logic [ptm_pkg::S_DATA_W-1:0] d);
            int unsigned slot, n, row, idx, k, col;
            logic        neg, sat;
            longint      prod, sum, rv;
            slot = 32'(d[9:0]);
            col  = 32'(d[89:74]);
            sat  = 1'b0;
            rv   = 0;
            if (fn == ptm_pkg::FUNC_LOAD)
            begin
                if (slot < N_TERMS)
                begin
                    flip[slot] = d[25:10];
                    zmsk[slot] = d[41:26];
                    ymsk[slot] = d[57:42];
                    coef[slot] = d[73:58];
                end
            end
            else if (fn == ptm_pkg::FUNC_CLEAR)
            begin
                foreach (acc[i]) acc[i] = 0;
            end
            else if (fn == ptm_pkg::FUNC_APPLY)
            begin
                n = (term_count > N_TERMS) ? N_TERMS : term_count;
                for (int t = 0; t < n; t++)
                begin
                    row = col ^ 32'(flip[t]);
                    k   = $countones(ymsk[t]);
                    if (row < row_low || row >= row_high) continue;
                    idx = row - row_low;
                    if (idx >= N_ACC || k[0]) continue;
                    neg  = (^(col[15:0] & zmsk[t])) ^ k[1] ^ (^(row[15:0] & ymsk[t]));
                    prod = longint'(coef[t]) * longint'($signed(d[105:90]));
                    if (neg) prod = -prod;
                    sum = acc[idx] + prod;
                    if (sum > 64'sd549755813887)
                    begin
                        sum = 64'sd549755813887;
                        sat = 1'b1;
                    end
                    else if (sum < -64'sd549755813888)
                    begin
                        sum = -64'sd549755813888;
                        sat = 1'b1;
                    end
                    acc[idx] = sum;
                end
            end
            else
            begin
                if (slot < N_ACC) rv = acc[slot];
            end
            pending_q.push_back({sat, rv[39:0]});
        endfunction

        // compare one result with the oldest expectation
        function void check_result(logic [ptm_pkg::M_DATA_W-1:0] d, logic u);
            logic [40:0] want;
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result read_value=%h saturated=%b", $time, d, u);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            if (d !== want[39:0])
            begin
                $display("%0t: read_value expected %h actual %h", $time, want[39:0], d);
                errors++;
            end
            if (u !== want[40])
            begin
                $display("%0t: saturated expected %b actual %b", $time, want[40], u);
                errors++;
            end
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [ptm_pkg::S_DATA_W-1:0]   s_tdata;
    logic [ptm_pkg::FUNC_W-1:0]     s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [ptm_pkg::M_DATA_W-1:0]   m_tdata;
    logic [0:0]                     m_tuser;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [ptm_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [ptm_pkg::CFG_DATA_W-1:0] cfg_data;

    matvec_scoreboard sb;
    bit          idle_on;
    bit          hold_done;
    int unsigned cycle_cnt;

    pauli_term_matvec_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // result check on each output transfer
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser[0]);
    end

    // receiver: random stalls plus one long hold-off
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (!hold_done && cycle_cnt > 4000)
            begin
                m_tready <= 1'b0;
                repeat (600) @(posedge clk);
                hold_done = 1'b1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    function automatic logic [ptm_pkg::S_DATA_W-1:0] pack_item(
        logic [9:0] slot, logic [15:0] fl, logic [15:0] z, logic [15:0] y,
        logic [15:0] cf, logic [15:0] col, logic [15:0] x);
        return {6'd0, x, col, cf, y, z, fl, slot};
    endfunction

    // one input transfer, with an optional idle burst first
    task automatic send_item(logic [ptm_pkg::FUNC_W-1:0] fn,
                             logic [ptm_pkg::S_DATA_W-1:0] d);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= d;
        do @(posedge clk); while (!s_tready);
        sb.note_item(fn, d);
    endtask

    // wait until every expected result is back, then let the block settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // one configuration transfer, valid stays up for the caller to drop
    task automatic write_reg(logic [ptm_pkg::CFG_IDX_W-1:0] idx,
                             logic [ptm_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, val);
    endtask

    task automatic set_window(int unsigned tc, int unsigned lo, int unsigned hi);
        wait_drained();
        write_reg(ptm_pkg::CFG_TERM_COUNT, ptm_pkg::CFG_DATA_W'(tc));
        write_reg(ptm_pkg::CFG_ROW_LOW, ptm_pkg::CFG_DATA_W'(lo));
        write_reg(ptm_pkg::CFG_ROW_HIGH, ptm_pkg::CFG_DATA_W'(hi));
        cfg_valid <= 1'b0;
    endtask

    // one random item, mostly columns within 1024 above the window's low edge
    task automatic send_random();
        int unsigned r;
        logic [15:0] fl, col;
        r  = $urandom_range(0, 99);
        fl = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 31));
        if ($urandom_range(0, 3) == 0)
            col = 16'($urandom);
        else
            col = 16'(sb.row_low + $urandom_range(0, 1023));
        if (r < 20)
            send_item(ptm_pkg::FUNC_LOAD, pack_item(
                ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, N_TERMS-1)),
                fl, 16'($urandom), 16'($urandom) & 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom)));
        else if (r < 21)
            send_item(ptm_pkg::FUNC_CLEAR, pack_item(10'($urandom), 0, 0, 0, 0, 0, 0));
        else if (r < 70)
            send_item(ptm_pkg::FUNC_APPLY, pack_item(10'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom), 16'($urandom), col, 16'($urandom)));
        else
            send_item(ptm_pkg::FUNC_READ, pack_item(
                ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 63)),
                16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom)));
    endtask

    initial
    begin
        int unsigned tc_set [N_PHASES] = '{64, 127, 17, 64, 1, 0, 40, 64};
        int unsigned lo_set [N_PHASES] = '{0, 0, 65535, 65000, 500, 0, 300, 0};
        int unsigned hi_set [N_PHASES] = '{1024, 65536, 65536, 65536, 100, 0, 900, 1024};
        sb = new();
        sb.reset_state();
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        cycle_cnt = 0;
        idle_on   = 1'b1;
        hold_done = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: no terms active, out-of-range load slots, last and first read slots
        send_item(ptm_pkg::FUNC_APPLY, pack_item(0, 0, 0, 0, 0, 16'hFFFF, 16'h7FFF));
        send_item(ptm_pkg::FUNC_READ, pack_item(10'd1023, 0, 0, 0, 0, 0, 0));
        send_item(ptm_pkg::FUNC_READ, pack_item(10'd0, 0, 0, 0, 0, 0, 0));
        send_item(ptm_pkg::FUNC_LOAD,
            pack_item(10'd64, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 0, 0));
        send_item(ptm_pkg::FUNC_LOAD, pack_item(10'd1023, 16'hFFFF, 0, 0, 16'h8000, 0, 0));
        // fill every slot with the most negative identity term
        for (int s = 0; s < N_TERMS; s++)
            send_item(ptm_pkg::FUNC_LOAD, pack_item(10'(s), 0, 0, 0, 16'h8000, 0, 0));
        set_window(64, 0, 1024);
        // drive two rows into positive and negative saturation
        for (int i = 0; i < 9; i++)
        begin
            send_item(ptm_pkg::FUNC_APPLY, pack_item(0, 0, 0, 0, 0, 16'd5, 16'h8000));
            send_item(ptm_pkg::FUNC_APPLY, pack_item(0, 0, 0, 0, 0, 16'd6, 16'h7FFF));
        end
        send_item(ptm_pkg::FUNC_READ, pack_item(10'd5, 0, 0, 0, 0, 0, 0));
        send_item(ptm_pkg::FUNC_READ, pack_item(10'd6, 0, 0, 0, 0, 0, 0));
        send_item(ptm_pkg::FUNC_CLEAR, pack_item(0, 0, 0, 0, 0, 0, 0));
        send_item(ptm_pkg::FUNC_READ, pack_item(10'd5, 0, 0, 0, 0, 0, 0));
        // odd Y count term, and a term with all masks set
        send_item(ptm_pkg::FUNC_LOAD,
            pack_item(10'd0, 16'h0001, 0, 16'h0001, 16'h7FFF, 0, 0));
        send_item(ptm_pkg::FUNC_LOAD,
            pack_item(10'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h1000, 0, 0));
        send_item(ptm_pkg::FUNC_APPLY, pack_item(0, 0, 0, 0, 0, 16'hFFFF, 16'h4000));
        send_item(ptm_pkg::FUNC_READ, pack_item(10'd0, 0, 0, 0, 0, 0, 0));

        // random phases under several window settings
        for (int p = 0; p < N_PHASES; p++)
        begin
            set_window(tc_set[p], lo_set[p], hi_set[p]);
            if (p == N_PHASES - 1) idle_on = 1'b0;
            for (int i = 0; i < 75; i++)
                send_random();
        end

        wait_drained();
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
